// File: hw/rtl/ecd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_pkg: shared types and constants for the epoch to calendar date unit
// Stage count, pipeline control struct, reciprocal multipliers for the
// constant divisions and the month start table.
// ----------------------------------------------------------------------------
package ecd_pkg;

  localparam int unsigned STAGES = 8;

  typedef struct packed {
    logic [STAGES-1:0] ld;
    logic [STAGES-1:0] vld;
  } ecd_ctl_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } ecd_tod_t;

  localparam logic [31:0] SEC_PER_DAY = 32'd86400;
  localparam logic [21:0] JDN_EPOCH   = 22'd2440588;
  localparam logic [21:0] JDN_BIAS    = 22'd32044;
  localparam logic [23:0] DAYS_400Y   = 24'd146097;
  localparam logic [17:0] DAYS_4Y     = 18'd1461;
  localparam logic [15:0] YEAR_BIAS   = 16'd6800;

  // ceil(2^k / d) reciprocals, exact over the operand range in use
  localparam longint unsigned DAY_MUL_L = ((64'd1 << 35) + 64'd674) / 64'd675;
  localparam longint unsigned MIN_MUL_L = ((64'd1 << 23) + 64'd59) / 64'd60;
  localparam longint unsigned HR_MUL_L  = ((64'd1 << 17) + 64'd59) / 64'd60;
  localparam longint unsigned WK_MUL_L  = ((64'd1 << 25) + 64'd6) / 64'd7;
  localparam longint unsigned CEN_MUL_L = ((64'd1 << 42) + 64'd146096) / 64'd146097;
  localparam longint unsigned YR_MUL_L  = ((64'd1 << 30) + 64'd1460) / 64'd1461;
  localparam longint unsigned MON_MUL_L = ((64'd1 << 19) + 64'd152) / 64'd153;

  localparam logic [50:0] DAY_MUL = 51'(DAY_MUL_L);
  localparam logic [34:0] MIN_MUL = 35'(MIN_MUL_L);
  localparam logic [22:0] HR_MUL  = 23'(HR_MUL_L);
  localparam logic [44:0] WK_MUL  = 45'(WK_MUL_L);
  localparam logic [48:0] CEN_MUL = 49'(CEN_MUL_L);
  localparam logic [38:0] YR_MUL  = 39'(YR_MUL_L);
  localparam logic [22:0] MON_MUL = 23'(MON_MUL_L);

  // days from March 1 to the start of month m (March based)
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] res;
    unique case (m)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// File: hw/rtl/epoch_to_calendar_date_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_unit: epoch seconds to Gregorian date and time
// Eight-stage pipeline: day split, then time-of-day and Julian-day paths
// side by side.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | in_epoch_seconds
//  out     | out_valid / out_stall| out_year_since_2000 .. out_second_of_minute
//
//  out_valid rises once an accepted item has passed all eight register stages;
//  one item per cycle while out_stall is low.
//  Each stage puts at most one reciprocal multiply on any path.
//  Synchronous active-low reset empties the pipeline; no payload reset.
//  out_stall holds the last stage; earlier stages keep filling bubbles,
//  so in_stall rises only when all eight stages hold an item.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_epoch_seconds,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] out_year_since_2000,
  output logic [3:0]        out_month_number,
  output logic [4:0]        out_day_of_month,
  output logic [2:0]        out_weekday,
  output logic [4:0]        out_hour_of_day,
  output logic [5:0]        out_minute_of_hour,
  output logic [5:0]        out_second_of_minute
);

  ecd_pkg::ecd_ctl_t ctl;
  ecd_pkg::ecd_tod_t hms;
  logic [15:0]       days;
  logic [16:0]       tod;
  logic [7:0]        year;

  ecd_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .ctl       (ctl)
  );

  ecd_day_split u_day (
    .clk  (clk),
    .ctl  (ctl),
    .secs (in_epoch_seconds),
    .days (days),
    .tod  (tod)
  );

  ecd_tod_split u_tod (
    .clk (clk),
    .ctl (ctl),
    .tod (tod),
    .hms (hms)
  );

  ecd_date_calc u_date (
    .clk   (clk),
    .ctl   (ctl),
    .days  (days),
    .year  (year),
    .month (out_month_number),
    .mday  (out_day_of_month),
    .wday  (out_weekday)
  );

  assign out_valid            = ctl.vld[ecd_pkg::STAGES-1];
  assign out_year_since_2000  = year;
  assign out_hour_of_day      = hms.hour;
  assign out_minute_of_hour   = hms.minute;
  assign out_second_of_minute = hms.second;

  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&ctl.vld))
    else $error("input stalled with an empty stage");

  a_occupancy : assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ($countones(ctl.vld) == $countones($past(ctl.vld))
               + int'($past(in_valid && !in_stall))
               - int'($past(out_valid && !out_stall))))
    else $error("pipeline lost or duplicated an item");

  a_month_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_number >= 4'd1 && out_month_number <= 4'd12
                   && out_day_of_month != 5'd0))
    else $error("month or day out of range");

  a_time_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weekday <= 3'd6 && out_hour_of_day <= 5'd23
                   && out_minute_of_hour <= 6'd59 && out_second_of_minute <= 6'd59))
    else $error("weekday or time of day out of range");

endmodule

// File: hw/rtl/ecd_pipe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_pipe_ctrl: valid tracking and stage load enables
// Each stage advances when empty or when the stage after it advances.
// ----------------------------------------------------------------------------
module ecd_pipe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_stall,
  output logic             in_stall,
  output ecd_pkg::ecd_ctl_t ctl
);

  localparam int unsigned S = ecd_pkg::STAGES;

  logic [S-1:0] vld_r;
  logic [S-1:0] vld_nxt;
  logic [S-1:0] adv;

  always_comb begin
    adv[S-1] = !vld_r[S-1] || !out_stall;
    for (int i = S - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int i = 1; i < S; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !adv[0];
  assign ctl.ld   = adv & {vld_r[S-2:0], in_valid};
  assign ctl.vld  = vld_r;

endmodule

// File: hw/rtl/ecd_day_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_day_split: whole days and seconds of day
// Stage 1 divides by 86400 through a reciprocal multiply, stage 2 forms
// the remainder.
// ----------------------------------------------------------------------------
module ecd_day_split (
  input  logic              clk,
  input  ecd_pkg::ecd_ctl_t ctl,
  input  logic [31:0]       secs,
  output logic [15:0]       days,
  output logic [16:0]       tod
);

  logic [50:0] day_prod;
  logic [15:0] days1_nxt;
  logic [15:0] days1_r;
  logic [31:0] secs1_r;
  logic [31:0] tod_full;
  logic [16:0] tod2_nxt;
  logic [16:0] tod2_r;
  logic [15:0] days2_r;

  assign day_prod  = {26'd0, secs[31:7]} * ecd_pkg::DAY_MUL;
  assign days1_nxt = day_prod[50:35];

  assign tod_full = secs1_r - {16'd0, days1_r} * ecd_pkg::SEC_PER_DAY;
  assign tod2_nxt = tod_full[16:0];

  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      days1_r <= days1_nxt;
      secs1_r <= secs;
    end
    if (ctl.ld[1]) begin
      days2_r <= days1_r;
      tod2_r  <= tod2_nxt;
    end
  end

  assign days = days2_r;
  assign tod  = tod2_r;

endmodule

// File: hw/rtl/ecd_tod_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_tod_split: hour, minute and second from seconds of day
// Divide by 60 twice, then delay to line up with the date path.
// ----------------------------------------------------------------------------
module ecd_tod_split (
  input  logic              clk,
  input  ecd_pkg::ecd_ctl_t ctl,
  input  logic [16:0]       tod,
  output ecd_pkg::ecd_tod_t hms
);

  logic [34:0] min_prod;
  logic [10:0] mins3_nxt;
  logic [10:0] mins3_r;
  logic [16:0] tod3_r;

  logic [16:0] sec_full;
  logic [22:0] hr_prod;
  logic [5:0]  sec4_nxt;
  logic [4:0]  hour4_nxt;
  logic [5:0]  sec4_r;
  logic [4:0]  hour4_r;
  logic [10:0] mins4_r;

  logic [10:0]       min_full;
  ecd_pkg::ecd_tod_t tod5_nxt;
  ecd_pkg::ecd_tod_t tod5_r;
  ecd_pkg::ecd_tod_t tdl_r [3];

  assign min_prod  = {18'd0, tod} * ecd_pkg::MIN_MUL;
  assign mins3_nxt = min_prod[33:23];

  assign sec_full  = tod3_r - {6'd0, mins3_r} * 17'd60;
  assign sec4_nxt  = sec_full[5:0];
  assign hr_prod   = {12'd0, mins3_r} * ecd_pkg::HR_MUL;
  assign hour4_nxt = hr_prod[21:17];

  assign min_full = mins4_r - {6'd0, hour4_r} * 11'd60;
  always_comb begin
    tod5_nxt.hour   = hour4_r;
    tod5_nxt.minute = min_full[5:0];
    tod5_nxt.second = sec4_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      mins3_r <= mins3_nxt;
      tod3_r  <= tod;
    end
    if (ctl.ld[3]) begin
      sec4_r  <= sec4_nxt;
      hour4_r <= hour4_nxt;
      mins4_r <= mins3_r;
    end
    if (ctl.ld[4]) begin
      tod5_r <= tod5_nxt;
    end
    if (ctl.ld[5]) begin
      tdl_r[0] <= tod5_r;
    end
    if (ctl.ld[6]) begin
      tdl_r[1] <= tdl_r[0];
    end
    if (ctl.ld[7]) begin
      tdl_r[2] <= tdl_r[1];
    end
  end

  assign hms = tdl_r[2];

endmodule

// File: hw/rtl/ecd_date_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecd_date_calc: Julian day number to Gregorian date and weekday
// Six stages: 400-year cycle, 4-year cycle, day of year, month, then
// final date assembly.
// ----------------------------------------------------------------------------
module ecd_date_calc (
  input  logic              clk,
  input  ecd_pkg::ecd_ctl_t ctl,
  input  logic [15:0]       days,
  output logic [7:0]        year,
  output logic [3:0]        month,
  output logic [4:0]        mday,
  output logic [2:0]        wday
);

  // stage 3
  logic [21:0] jdn;
  logic [21:0] a_val;
  logic [44:0] wk_prod;
  logic [48:0] cen_prod;
  logic [21:0] jdn3_r;
  logic [21:0] a3_r;
  logic [18:0] q7_3_r;
  logic [6:0]  b3_r;

  // stage 4
  logic [21:0] dow_full;
  logic [23:0] cen_days;
  logic [21:0] c_full;
  logic [2:0]  dow4_r;
  logic [16:0] c4_r;
  logic [6:0]  b4_r;

  // stage 5
  logic [38:0] yr_prod;
  logic [6:0]  d5_nxt;
  logic [6:0]  d5_r;
  logic [16:0] c5_r;
  logic [6:0]  b5_r;
  logic [2:0]  dow5_r;

  // stage 6
  logic [17:0] yr_days;
  logic [16:0] e_full;
  logic [8:0]  e6_r;
  logic [6:0]  d6_r;
  logic [6:0]  b6_r;
  logic [2:0]  dow6_r;

  // stage 7
  logic [10:0] e5x;
  logic [22:0] mon_prod;
  logic [3:0]  m7_r;
  logic [8:0]  e7_r;
  logic [6:0]  d7_r;
  logic [6:0]  b7_r;
  logic [2:0]  dow7_r;

  // stage 8
  logic        late;
  logic [8:0]  mday_full;
  logic [15:0] year_full;
  logic [7:0]  year_nxt;
  logic [3:0]  month_nxt;
  logic [7:0]  year8_r;
  logic [3:0]  month8_r;
  logic [4:0]  mday8_r;
  logic [2:0]  dow8_r;

  assign jdn      = {6'd0, days} + ecd_pkg::JDN_EPOCH;
  assign a_val    = jdn + ecd_pkg::JDN_BIAS;
  assign wk_prod  = {23'd0, jdn} * ecd_pkg::WK_MUL;
  assign cen_prod = {25'd0, a_val, 2'b11} * ecd_pkg::CEN_MUL;

  assign dow_full = jdn3_r - {3'd0, q7_3_r} * 22'd7;
  assign cen_days = {17'd0, b3_r} * ecd_pkg::DAYS_400Y;
  assign c_full   = a3_r - cen_days[23:2];

  assign yr_prod = {20'd0, c4_r, 2'b11} * ecd_pkg::YR_MUL;
  assign d5_nxt  = yr_prod[36:30];

  assign yr_days = {11'd0, d5_r} * ecd_pkg::DAYS_4Y;
  assign e_full  = c5_r - {1'b0, yr_days[17:2]};

  assign e5x      = {2'd0, e6_r} * 11'd5 + 11'd2;
  assign mon_prod = {12'd0, e5x} * ecd_pkg::MON_MUL;

  assign late      = (m7_r >= 4'd10);
  assign mday_full = e7_r - ecd_pkg::month_start(m7_r) + 9'd1;
  assign month_nxt = late ? (m7_r - 4'd9) : (m7_r + 4'd3);
  assign year_full = {9'd0, b7_r} * 16'd100 + {9'd0, d7_r} + {15'd0, late}
                     - ecd_pkg::YEAR_BIAS;
  assign year_nxt  = year_full[7:0];

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      jdn3_r <= jdn;
      a3_r   <= a_val;
      q7_3_r <= wk_prod[43:25];
      b3_r   <= cen_prod[48:42];
    end
    if (ctl.ld[3]) begin
      dow4_r <= dow_full[2:0];
      c4_r   <= c_full[16:0];
      b4_r   <= b3_r;
    end
    if (ctl.ld[4]) begin
      d5_r   <= d5_nxt;
      c5_r   <= c4_r;
      b5_r   <= b4_r;
      dow5_r <= dow4_r;
    end
    if (ctl.ld[5]) begin
      e6_r   <= e_full[8:0];
      d6_r   <= d5_r;
      b6_r   <= b5_r;
      dow6_r <= dow5_r;
    end
    if (ctl.ld[6]) begin
      m7_r   <= mon_prod[22:19];
      e7_r   <= e6_r;
      d7_r   <= d6_r;
      b7_r   <= b6_r;
      dow7_r <= dow6_r;
    end
    if (ctl.ld[7]) begin
      year8_r  <= year_nxt;
      month8_r <= month_nxt;
      mday8_r  <= mday_full[4:0];
      dow8_r   <= dow7_r;
    end
  end

  assign year  = year8_r;
  assign month = month8_r;
  assign mday  = mday8_r;
  assign wday  = dow8_r;

endmodule
